// File: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Item layouts, operation codes, control characters and console geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default console geometry
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  // Cursor register widths cover the whole geometry range
  localparam int COL_W = 7;
  localparam int ROW_W = 5;

  localparam int ADDR_W  = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COLOR       = 1'b0,
    CFG_BACKGROUND_COLOR = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        character;
    logic [ADDR_W-1:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_location;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

endpackage

// File: hw/rtl/tcw_fb_ram.sv
// ----------------------------------------------------------------------------
// tcw_fb_ram: framebuffer cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_fb_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: console sequencer
// Cursor and colour registers, put/clear/read decode, scroll copy and blank
// sweeps over the framebuffer memory, and the registered result item.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH,
  parameter int AW        = $clog2(COLUMNS * ROWS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [CELL_W-1:0]    mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [CELL_W-1:0]    mem_rdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int PH_W  = $clog2(TAB_WIDTH);
  localparam int LOC_W = ROW_W + COL_W;

  localparam logic [AW-1:0]    LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0]    BOTTOM_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0]    ROW_STRIDE  = AW'(COLUMNS);
  localparam logic [COL_W:0]   COL_LIMIT   = (COL_W + 1)'(COLUMNS);
  localparam logic [COL_W:0]   TAB_STEP    = (COL_W + 1)'(TAB_WIDTH);
  localparam logic [ROW_W-1:0] ROW_LIMIT   = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(ROWS - 1);
  localparam logic [PH_W-1:0]  PH_LAST     = PH_W'(TAB_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_COPY,
    ST_DRAIN,
    ST_RESP
  } state_t;

  state_t             state;
  logic [AW-1:0]      cnt;
  logic               respond;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [PH_W-1:0]    phase;   // col modulo TAB_WIDTH, tracked incrementally
  logic [COLOR_W-1:0] text_color;
  logic [COLOR_W-1:0] background_color;
  logic               read_hit;
  logic               pend;
  logic [AW-1:0]      pend_addr;

  logic               accept;
  logic               printable;
  logic               do_print;
  logic [COL_W:0]     col_tmp;
  logic [ROW_W-1:0]   row_tmp;
  logic [PH_W-1:0]    phase_tmp;
  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;
  logic [PH_W-1:0]    phase_next;
  logic               scroll_need;
  logic [AW-1:0]      cursor_addr;
  logic [LOC_W-1:0]   loc;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign printable = !in_data.character[7] && (in_data.character >= CH_SPACE);
  assign do_print  = accept && (in_data.operation == OP_PUT) && printable;
  assign cursor_addr = AW'(row * COLUMNS) + AW'(col);
  assign loc       = LOC_W'(row * COLUMNS) + LOC_W'(col);

  // Cursor movement for a put
  always_comb begin
    col_tmp   = {1'b0, col};
    row_tmp   = row;
    phase_tmp = phase;
    case (in_data.character)
      CH_BACKSPACE: begin
        if (col != '0) begin
          col_tmp   = {1'b0, col} - 1'b1;
          phase_tmp = (phase == '0) ? PH_LAST : phase - 1'b1;
        end
      end
      CH_TAB: begin
        col_tmp   = {1'b0, col} + TAB_STEP - (COL_W + 1)'(phase);
        phase_tmp = '0;
      end
      CH_LF: begin
        col_tmp   = '0;
        row_tmp   = row + 1'b1;
        phase_tmp = '0;
      end
      CH_CR: begin
        col_tmp   = '0;
        phase_tmp = '0;
      end
      default: begin
        if (printable) begin
          col_tmp   = {1'b0, col} + 1'b1;
          phase_tmp = (phase == PH_LAST) ? '0 : phase + 1'b1;
        end
      end
    endcase

    col_next   = col_tmp[COL_W-1:0];
    row_next   = row_tmp;
    phase_next = phase_tmp;
    if (col_tmp >= COL_LIMIT) begin
      col_next   = '0;
      row_next   = row_tmp + 1'b1;
      phase_next = '0;
    end
    scroll_need = (row_next == ROW_LIMIT);
    if (scroll_need) begin
      row_next = ROW_LAST;
    end
  end

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = BLANK_CELL;
    if (state == ST_FILL) begin
      mem_we = 1'b1;
    end else if (pend) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr;
      mem_wdata = mem_rdata;
    end else if (do_print) begin
      mem_we    = 1'b1;
      mem_waddr = cursor_addr;
      mem_wdata = {background_color, text_color, in_data.character};
    end

    mem_re    = (state == ST_COPY) ||
                (accept && (in_data.operation == OP_READ));
    mem_raddr = (state == ST_COPY) ? cnt : AW'(in_data.read_address);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_FILL;
      cnt              <= '0;
      respond          <= 1'b0;
      col              <= '0;
      row              <= '0;
      phase            <= '0;
      text_color       <= 4'hF;
      background_color <= 4'h0;
      read_hit         <= 1'b0;
      pend             <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TEXT_COLOR:       text_color       <= cfg_data;
          CFG_BACKGROUND_COLOR: background_color <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && (state != ST_RESP)) begin
        out_valid <= 1'b0;
      end

      // read cell cnt in copy, write it one row up next cycle
      pend <= (state == ST_COPY);

      case (state)
        ST_IDLE: begin
          if (accept) begin
            read_hit <= (in_data.operation == OP_READ) &&
                        (32'(in_data.read_address) < CELLS);
            case (in_data.operation)
              OP_PUT: begin
                col   <= col_next;
                row   <= row_next;
                phase <= phase_next;
                if (scroll_need) begin
                  state <= ST_COPY;
                  cnt   <= ROW_STRIDE;
                end else begin
                  state <= ST_RESP;
                end
              end
              OP_CLEAR: begin
                col     <= '0;
                row     <= '0;
                phase   <= '0;
                cnt     <= '0;
                respond <= 1'b1;
                state   <= ST_FILL;
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_COPY: begin
          pend_addr <= cnt - ROW_STRIDE;
          if (cnt == LAST_CELL) begin
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          cnt     <= BOTTOM_BASE;
          respond <= 1'b1;
          state   <= ST_FILL;
        end
        ST_FILL: begin
          if (cnt == LAST_CELL) begin
            state <= respond ? ST_RESP : ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.cursor_location <= loc[ADDR_W-1:0];
            out_data.cell_data       <= read_hit ? mem_rdata : '0;
            respond                  <= 1'b0;
            state                    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top: text console with cell framebuffer and cursor
// Put/clear/read items against a COLUMNS x ROWS framebuffer memory.
// ----------------------------------------------------------------------------
// Put, read and unused codes go from accept through the response state to
// the registered result item, which waits while out_stall is high. A put
// that scrolls moves every lower row up by one, then blanks the bottom row:
// one memory cell copied or blanked per cycle through the single write port.
// Clear blanks all ROWS*COLUMNS cells. One item at a time. Reset: cursor
// home, colours 15/0; a clearing pass blanks the framebuffer before any item.
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  tcw_ctrl #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_fb_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_fb_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: tb/sv/text_console_writer_top_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_top_tb: self-checking bench for the text console writer
// Drives put/clear/read items through the valid/stall channels and compares
// every result with a shadow copy of the framebuffer, cursor and colors.
// Random idling on both sides, a long output hold-off and several colors.
// ----------------------------------------------------------------------------
import tcw_pkg::*;

localparam logic [1:0] OP_UNUSED        = 2'd3;
localparam logic [7:0] CH_TOP_PRINTABLE = 8'h7F;
localparam int         CELL_COUNT       = DEF_ROWS * DEF_COLUMNS;

// Shadow of the console: predicts the result of each accepted item
class screen_shadow;
  logic [CELL_W-1:0]  cells [CELL_COUNT];
  int unsigned        col;
  int unsigned        row;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  out_item_t          due_results [$];
  int unsigned        errors;

  function new();
    blank_screen();
    fg     = 4'd15;
    bg     = 4'd0;
    errors = 0;
  endfunction

  function void blank_screen();
    foreach (cells[i]) cells[i] = BLANK_CELL;
    col = 0;
    row = 0;
  endfunction

  function void set_color(cfg_idx_t idx, logic [COLOR_W-1:0] value);
    case (idx)
      CFG_TEXT_COLOR:       fg = value;
      CFG_BACKGROUND_COLOR: bg = value;
      default: ;
    endcase
  endfunction

  function int unsigned cursor_index();
    return row * DEF_COLUMNS + col;
  endfunction

  function void put_char(logic [7:0] ch);
    if (ch == CH_BACKSPACE) begin
      if (col > 0) col--;
    end else if (ch == CH_TAB) begin
      col = col + DEF_TAB_WIDTH - (col % DEF_TAB_WIDTH);
    end else if (ch == CH_LF) begin
      col = 0;
      row++;
    end else if (ch == CH_CR) begin
      col = 0;
    end else if (ch >= CH_SPACE && ch <= CH_TOP_PRINTABLE) begin
      cells[row * DEF_COLUMNS + col] = {bg, fg, ch};
      col++;
    end
    if (col >= DEF_COLUMNS) begin
      col = 0;
      row++;
    end
    // scroll up one row, bottom row gets the fixed blank
    if (row >= DEF_ROWS) begin
      for (int i = 0; i < CELL_COUNT - DEF_COLUMNS; i++) cells[i] = cells[i + DEF_COLUMNS];
      for (int i = CELL_COUNT - DEF_COLUMNS; i < CELL_COUNT; i++) cells[i] = BLANK_CELL;
      row = DEF_ROWS - 1;
    end
  endfunction

  function void note_item(in_item_t it);
    out_item_t want;
    want = '0;
    case (it.operation)
      OP_PUT:   put_char(it.character);
      OP_CLEAR: blank_screen();
      OP_READ: begin
        if (it.read_address < CELL_COUNT) want.cell_data = cells[it.read_address];
      end
      default: ;
    endcase
    want.cursor_location = ADDR_W'(cursor_index());
    due_results.push_back(want);
  endfunction

  function void report(string what, int unsigned want, int unsigned got);
    errors++;
    $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      report("unexpected item, cursor_location", 0, got.cursor_location);
      return;
    end
    want = due_results.pop_front();
    if (got.cursor_location !== want.cursor_location)
      report("cursor_location", want.cursor_location, got.cursor_location);
    if (got.cell_data !== want.cell_data)
      report("cell_data", want.cell_data, got.cell_data);
  endfunction

  function int unsigned pending();
    return due_results.size();
  endfunction
endclass

module text_console_writer_top_tb;

  localparam int DRAIN_CYCLES    = CELL_COUNT + 16;
  localparam int HOLD_CYCLES     = 600;
  localparam int ITEMS_PER_PHASE = 475;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_data;

  screen_shadow shadow;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_requests  = 0;

  text_console_writer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic in_item_t make_item(logic [1:0] op, logic [7:0] ch,
                                         logic [ADDR_W-1:0] addr);
    in_item_t it;
    it.operation    = op;
    it.character    = ch;
    it.read_address = addr;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    int unsigned idx;
    it.character    = 8'($urandom);
    it.read_address = ADDR_W'($urandom);
    r = $urandom_range(99);
    if (r < 78) begin
      it.operation = OP_PUT;
      r = $urandom_range(99);
      if (r < 62)      it.character = 8'($urandom_range(CH_SPACE, CH_TOP_PRINTABLE));
      else if (r < 67) it.character = CH_LF;
      else if (r < 72) it.character = CH_TAB;
      else if (r < 77) it.character = CH_BACKSPACE;
      else if (r < 80) it.character = CH_CR;
    end else if (r < 80) begin
      it.operation = OP_CLEAR;
    end else if (r < 99) begin
      it.operation = OP_READ;
      // look back at what was just printed in 40% of reads
      if ($urandom_range(99) < 40) begin
        idx = shadow.cursor_index();
        if (idx >= 3) idx = idx - $urandom_range(1, 3);
        it.read_address = ADDR_W'(idx);
      end else begin
        it.read_address = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
      end
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    shadow.note_item(it);
  endtask

  // drop valid, wait for all results, then let a scroll or clear finish
  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TEXT_COLOR;
    cfg_data  <= fg;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_color(CFG_TEXT_COLOR, fg);
    cfg_index <= CFG_BACKGROUND_COLOR;
    cfg_data  <= bg;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_color(CFG_BACKGROUND_COLOR, bg);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_item(make_item(OP_PUT, CH_BACKSPACE, '0));   // backspace at column 0
    send_item(make_item(OP_PUT, 8'h41, '0));
    send_item(make_item(OP_PUT, CH_SPACE, '0));
    send_item(make_item(OP_PUT, CH_TOP_PRINTABLE, '0));
    send_item(make_item(OP_PUT, CH_BACKSPACE, '0));
    send_item(make_item(OP_READ, 8'hFF, 11'd2));
    send_item(make_item(OP_PUT, CH_TAB, '0));
    send_item(make_item(OP_PUT, CH_CR, '0));
    send_item(make_item(OP_PUT, CH_LF, '1));
    send_item(make_item(OP_PUT, 8'h00, '0));
    send_item(make_item(OP_PUT, 8'h1F, '0));
    send_item(make_item(OP_PUT, 8'h80, '0));
    send_item(make_item(OP_PUT, 8'hFF, '0));
    send_item(make_item(OP_READ, 8'h00, 11'd0));
    send_item(make_item(OP_READ, 8'h00, ADDR_W'(CELL_COUNT - 1)));
    send_item(make_item(OP_READ, 8'h00, ADDR_W'(CELL_COUNT)));    // out of range
    send_item(make_item(OP_READ, 8'hAA, '1));
    send_item(make_item(OP_UNUSED, 8'h55, 11'h555));
    send_item(make_item(OP_CLEAR, 8'h41, 11'd1));
    send_item(make_item(OP_READ, 8'h00, 11'd0));
  endtask

  initial begin
    logic [COLOR_W-1:0] fg_by_phase [4];
    logic [COLOR_W-1:0] bg_by_phase [4];
    int unsigned        send_by_phase [4];
    int unsigned        recv_by_phase [4];
    fg_by_phase   = '{4'd0, 4'd15, 4'd0, 4'($urandom)};
    bg_by_phase   = '{4'd15, 4'd15, 4'd0, 4'($urandom)};
    send_by_phase = '{0, 52, 0, 37};
    recv_by_phase = '{0, 0, 52, 37};
    shadow    = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TEXT_COLOR;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      write_colors(fg_by_phase[phase], bg_by_phase[phase]);
      send_idle_pct  = send_by_phase[phase];
      recv_stall_pct = recv_by_phase[phase];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((phase == 0 || phase == 3) && n == 150) hold_requests++;
        send_item(random_item());
      end
    end
    settle();
    if (shadow.errors == 0) begin
      $display("PASS text_console_writer_top");
    end else begin
      $display("FAIL text_console_writer_top");
    end
    $finish;
  end

  // result side: random stalls, long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) shadow.check_result(out_data);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #160_000_000;
    $display("FAIL text_console_writer_top");
    $finish;
  end

endmodule

// File: text_console_writer_top.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_fb_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer_top.sv
tb/sv/text_console_writer_top_tb.sv
